### sv/aks_pkg.sv
// Package with the S-box, round constant helper and shared types of the key schedule.
package aks_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned KeyHalfWidth = 64;
   localparam int unsigned RoundWidth = 4;
   localparam int unsigned RowWidth = 32;
   localparam logic [7:0] RconInit = 8'h01;
   localparam logic [7:0] RconPoly = 8'h1b;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SboxTable = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] gf_double(input logic [7:0] v);
      logic [7:0] d;
      d = {v[6:0], 1'b0};
      if (v[7]) begin
         d = d ^ RconPoly;
      end
      return d;
   endfunction

   typedef struct packed {
      logic [KeyHalfWidth-1:0] key_low;
      logic [KeyHalfWidth-1:0] key_high;
   } key_type;

   typedef struct packed {
      logic [KeyHalfWidth-1:0] round_key_low;
      logic [KeyHalfWidth-1:0] round_key_high;
      logic [RoundWidth-1:0]   round_number;
      logic                    last_key;
   } rsp_type;

endpackage

### sv/aks_if.sv
// Valid/ready channel interfaces for keys and round keys.
interface aks_req_if;
   logic                 valid;
   logic                 ready;
   aks_pkg::key_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface aks_rsp_if;
   logic                 valid;
   logic                 ready;
   aks_pkg::rsp_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/aks_round.sv
// Combinational single expansion step of the row-packed key schedule.
module aks_round (
   input  aks_pkg::key_type key_i,
   input  logic [7:0]       rcon_i,
   output aks_pkg::key_type key_o
);
   logic [31:0] r0, r1, r2, r3, n0, n1, n2, n3;

   function automatic logic [31:0] pxor(input logic [31:0] v);
      return v ^ (v << 8) ^ (v << 16) ^ (v << 24);
   endfunction

   function automatic logic [31:0] subc(input logic [31:0] v);
      return {24'h0, aks_pkg::SboxTable[v[31:24]]};
   endfunction

   always_comb begin
      r0 = key_i.key_low[31:0];
      r1 = key_i.key_low[63:32];
      r2 = key_i.key_high[31:0];
      r3 = key_i.key_high[63:32];
      n0 = pxor(r0 ^ subc(r1) ^ {24'h0, rcon_i});
      n1 = pxor(r1 ^ subc(r2));
      n2 = pxor(r2 ^ subc(r3));
      n3 = pxor(r3 ^ subc(r0));
      key_o.key_low = {n1, n0};
      key_o.key_high = {n3, n2};
   end
endmodule

### sv/aes128_key_schedule_rowpacked_core.sv
// Top level of the row-packed AES-128 key schedule.
//
// A key is taken on the req channel (valid/ready) and eleven round keys
// leave on the rsp channel, round 0 being the key itself, with last_key
// set on round ten.
// The key state register sits between the transfers: one expansion step
// of S-box lookups and XORs lies between it and the result register.
// The first round key appears in the cycle after the key transfer, and
// one round key follows in each cycle while the receiver takes them, so
// a key occupies the block through round ten; the next key is accepted
// at the edge at which round ten leaves the result register.
// When the receiver stalls, the result register holds and the schedule
// pauses without loss.
// Reset empties the result register and returns the block to idle.
module aes128_key_schedule_rowpacked_core #(
   parameter int unsigned NUM_ROUNDS = aks_pkg::NumRounds
) (
   input logic clock,
   input logic reset,
   aks_req_if.sink   req,
   aks_rsp_if.source rsp
);
   aks_pkg::key_type key_ff, key_in, step_key;
   logic [7:0] rcon_ff, rcon_in;
   logic [aks_pkg::RoundWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic out_valid_ff, out_valid_in;
   aks_pkg::rsp_type out_ff, out_in;
   logic out_free, take, advance;

   aks_round u_round (.key_i(key_ff), .rcon_i(rcon_ff), .key_o(step_key));

   assign out_free = !out_valid_ff || rsp.ready;
   assign req.ready = out_free && !busy_ff;
   assign take = req.valid && req.ready;
   assign advance = busy_ff && out_free;

   always_comb begin
      key_in = key_ff;
      rcon_in = rcon_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (take) begin
         key_in = req.payload;
         rcon_in = aks_pkg::RconInit;
         cnt_in = '0;
         busy_in = 1'b1;
         out_valid_in = 1'b1;
         out_in = {req.payload.key_low, req.payload.key_high,
                   {aks_pkg::RoundWidth{1'b0}}, 1'b0};
      end else if (advance) begin
         key_in = step_key;
         rcon_in = aks_pkg::gf_double(rcon_ff);
         cnt_in = cnt_ff + 1'b1;
         busy_in = (cnt_in != aks_pkg::RoundWidth'(NUM_ROUNDS));
         out_valid_in = 1'b1;
         out_in = {step_key.key_low, step_key.key_high, cnt_in,
                   (cnt_in == aks_pkg::RoundWidth'(NUM_ROUNDS))};
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         key_ff <= '0;
         rcon_ff <= aks_pkg::RconInit;
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         key_ff <= key_in;
         rcon_ff <= rcon_in;
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp.valid && rsp.payload.round_number == '0)
      else $error("key transfer did not load round zero");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.last_key |-> !busy_ff)
      else $error("schedule still busy on last round key");
   a_last_num: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.last_key ==
         (rsp.payload.round_number == aks_pkg::RoundWidth'(NUM_ROUNDS)))
      else $error("last flag and round number disagree");
   a_busy_valid: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rsp.valid)
      else $error("busy without a pending round key");
endmodule

### bench/tb.sv
// Testbench for the row-packed AES-128 key schedule: directed and random keys checked against a predictor.
module tb;

   localparam int unsigned RandomKeys = 500;
   localparam int unsigned StallLimit = 2000;

   typedef struct {
      logic [63:0] key_low;
      logic [63:0] key_high;
   } key_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned errors = 0;
   int unsigned keys_sent = 0;
   int unsigned round_keys_seen = 0;
   int unsigned idle_cycles = 0;
   bit long_hold = 1'b0;
   bit stim_done = 1'b0;
   aks_pkg::rsp_type round_keys_due[$];

   aks_req_if req ();
   aks_rsp_if rsp ();

   aes128_key_schedule_rowpacked_core dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] running_xor(input logic [31:0] v);
      return v ^ (v << 8) ^ (v << 16) ^ (v << 24);
   endfunction

   function automatic logic [31:0] sub_top(input logic [31:0] row);
      return {24'h0, aks_pkg::SboxTable[row[31:24]]};
   endfunction

   task automatic schedule_key(input logic [63:0] lo, input logic [63:0] hi);
      logic [31:0] r0, r1, r2, r3, n0, n1, n2, n3;
      logic [7:0] rcon;
      aks_pkg::rsp_type rk;
      r0 = lo[31:0]; r1 = lo[63:32]; r2 = hi[31:0]; r3 = hi[63:32];
      rcon = 8'h01;
      for (int k = 0; k <= aks_pkg::NumRounds; k++) begin
         if (k > 0) begin
            n0 = running_xor(r0 ^ sub_top(r1) ^ {24'h0, rcon});
            n1 = running_xor(r1 ^ sub_top(r2));
            n2 = running_xor(r2 ^ sub_top(r3));
            n3 = running_xor(r3 ^ sub_top(r0));
            r0 = n0; r1 = n1; r2 = n2; r3 = n3;
            rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
         end
         rk.round_key_low = {r1, r0};
         rk.round_key_high = {r3, r2};
         rk.round_number = k[3:0];
         rk.last_key = (k == aks_pkg::NumRounds);
         round_keys_due.push_back(rk);
      end
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      errors++;
   endtask

   task automatic send_key(input logic [63:0] lo, input logic [63:0] hi);
      int unsigned gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= '{key_low: lo, key_high: hi};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      schedule_key(lo, hi);
      keys_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req.valid <= 1'b0;
      while (round_keys_due.size() != 0) @(negedge clock);
   endtask

   key_row_type directed [] = '{
      '{64'h0, 64'h0},
      '{64'hffffffff_ffffffff, 64'hffffffff_ffffffff},
      '{64'h8815f7ab_2b7e1516, 64'h09cf4f3c_28aed2a6},
      '{64'h0, 64'hffffffff_ffffffff},
      '{64'hffffffff_ffffffff, 64'h0},
      '{64'haaaaaaaa_aaaaaaaa, 64'h55555555_55555555},
      '{64'h80000000_00000001, 64'h00000001_80000000},
      '{64'h01234567_89abcdef, 64'hfedcba98_76543210}
   };

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_key(directed[i].key_low, directed[i].key_high);
      drain();
      for (int i = 0; i < RandomKeys; i++) begin
         if (i == 40) long_hold = 1'b1;
         if (i == 200) drain();
         case ($urandom_range(0, 9))
            0: send_key({2{$urandom}} & {$urandom, $urandom}, '0);
            1: send_key('1, {$urandom, $urandom});
            default: send_key({$urandom, $urandom}, {$urandom, $urandom});
         endcase
      end
      req.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp.ready <= 1'b0;
            repeat (60) @(negedge clock);
         end
         if ($urandom_range(0, 3) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      aks_pkg::rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         round_keys_seen++;
         if (round_keys_due.size() == 0) begin
            report("unexpected round key", 64'(rsp.payload.round_number), 64'h0);
         end else begin
            want = round_keys_due.pop_front();
            if (rsp.payload.round_key_low !== want.round_key_low)
               report("round_key_low", rsp.payload.round_key_low, want.round_key_low);
            if (rsp.payload.round_key_high !== want.round_key_high)
               report("round_key_high", rsp.payload.round_key_high, want.round_key_high);
            if (rsp.payload.round_number !== want.round_number)
               report("round_number", 64'(rsp.payload.round_number),
                      64'(want.round_number));
            if (rsp.payload.last_key !== want.last_key)
               report("last_key", 64'(rsp.payload.last_key), 64'(want.last_key));
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("no transfer for %0d cycles", StallLimit);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (round_keys_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d keys scheduled, %0d round keys checked, with random stalls on both sides.",
               keys_sent, round_keys_seen);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
